// ----- design/uirb_pkg.sv -----
package uirb_pkg;

   localparam logic [1:0] CMD_IRQ  = 2'd0;
   localparam logic [1:0] CMD_GETC = 2'd1;
   localparam logic [1:0] CMD_PUTC = 2'd2;

   localparam logic [7:0] IIR_MASK = 8'h0E;
   localparam logic [7:0] IIR_RX   = 8'h04;
   localparam logic [7:0] IIR_TX   = 8'h02;

   localparam logic [7:0] CHAR_CR = 8'h0D;
   localparam logic [7:0] CHAR_LF = 8'h0A;

   typedef struct packed {
      logic [1:0] cmd;
      logic [7:0] status_code;
      logic [7:0] rx_byte;
      logic [7:0] put_byte;
   } req_type;

   typedef struct packed {
      logic       tx_valid;
      logic [7:0] tx_byte;
      logic       tx_irq_enabled;
      logic       read_valid;
      logic [7:0] read_byte;
      logic       rx_notify;
      logic       tx_notify;
      logic [6:0] rx_level;
      logic [6:0] tx_level;
   } rsp_type;

endpackage

// ----- design/uirb_ram.sv -----
module uirb_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 64,
   localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
   input  logic              clock,
   input  logic              wr_en,
   input  logic [ADDR_W-1:0] wr_addr,
   input  logic [WIDTH-1:0]  wr_data,
   input  logic              rd_en,
   input  logic [ADDR_W-1:0] rd_addr,
   output logic [WIDTH-1:0]  rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- design/uart_irq_dual_ring_buffer.sv -----
// A request is held in in_ff, then its result in out_ff; each ring is one RAM with one write
// and one registered read port. Throughput: one word per cycle unless rsp_ready stalls.
// The read data of a pop is taken from the RAM output register while the result is shown.
// Reset is synchronous and active high: heads, counts, the enable bit and valid flags clear.
// Ring contents are not cleared; only slots that were written are ever read.
module uart_irq_dual_ring_buffer
   import uirb_pkg::*;
#(
   parameter int RING_DEPTH = 64
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   localparam int PTR_W = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
   localparam int CNT_W = $clog2(RING_DEPTH + 1);
   localparam logic [CNT_W-1:0] DEPTH_C = CNT_W'(RING_DEPTH);
   localparam logic [CNT_W:0]   DEPTH_S = (CNT_W + 1)'(RING_DEPTH);
   localparam logic [PTR_W-1:0] LAST_P  = PTR_W'(RING_DEPTH - 1);

   req_type          in_ff;
   logic             in_valid_ff;
   rsp_type          out_ff, out_in;
   logic             out_valid_ff;

   logic [PTR_W-1:0] rx_head_ff, rx_head_in, tx_head_ff, tx_head_in;
   logic [CNT_W-1:0] rx_count_ff, rx_count_in, tx_count_ff, tx_count_in;
   logic             tx_irq_ff, tx_irq_in;

   logic             advance, exec;
   logic [7:0]       code;
   logic [CNT_W:0]   rx_sum, tx_sum;
   logic [PTR_W-1:0] rx_tail, tx_tail;

   logic             rx_we, rx_re, tx_we, tx_re;
   logic [7:0]       rx_wd, tx_wd, rx_q, tx_q;

   assign advance   = !out_valid_ff || rsp_ready;
   assign exec      = in_valid_ff && advance;
   assign req_ready = !in_valid_ff || advance;

   always_comb begin
      code = in_ff.status_code & IIR_MASK;

      rx_sum = (CNT_W + 1)'(rx_head_ff) + (CNT_W + 1)'(rx_count_ff);
      if (rx_sum >= DEPTH_S) begin
         rx_sum = rx_sum - DEPTH_S;
      end
      rx_tail = rx_sum[PTR_W-1:0];

      tx_sum = (CNT_W + 1)'(tx_head_ff) + (CNT_W + 1)'(tx_count_ff);
      if (tx_sum >= DEPTH_S) begin
         tx_sum = tx_sum - DEPTH_S;
      end
      tx_tail = tx_sum[PTR_W-1:0];

      rx_head_in  = rx_head_ff;
      rx_count_in = rx_count_ff;
      tx_head_in  = tx_head_ff;
      tx_count_in = tx_count_ff;
      tx_irq_in   = tx_irq_ff;
      rx_we = 1'b0;
      rx_re = 1'b0;
      tx_we = 1'b0;
      tx_re = 1'b0;
      rx_wd = in_ff.rx_byte;
      tx_wd = in_ff.rx_byte;
      out_in = '0;

      case (in_ff.cmd)
         CMD_IRQ: begin
            if (code == IIR_RX) begin
               rx_we = 1'b1;
               tx_we = 1'b1;
               if (rx_count_ff != DEPTH_C) begin
                  rx_count_in = rx_count_ff + CNT_W'(1);
                  out_in.rx_notify = 1'b1;
               end
               if (tx_count_ff != DEPTH_C) begin
                  tx_count_in = tx_count_ff + CNT_W'(1);
               end
               tx_irq_in = 1'b1;
            end else if (code == IIR_TX) begin
               if (tx_count_ff != '0) begin
                  tx_re = 1'b1;
                  tx_head_in = (tx_head_ff == LAST_P) ? '0 : tx_head_ff + PTR_W'(1);
                  tx_count_in = tx_count_ff - CNT_W'(1);
                  out_in.tx_valid = 1'b1;
                  out_in.tx_notify = 1'b1;
                  if (tx_count_ff == CNT_W'(1)) begin
                     tx_irq_in = 1'b0;
                  end
               end
            end
         end
         CMD_GETC: begin
            if (rx_count_ff != '0) begin
               rx_re = 1'b1;
               rx_head_in = (rx_head_ff == LAST_P) ? '0 : rx_head_ff + PTR_W'(1);
               rx_count_in = rx_count_ff - CNT_W'(1);
               out_in.read_valid = 1'b1;
            end
         end
         CMD_PUTC: begin
            tx_wd = in_ff.put_byte;
            if (tx_count_ff != DEPTH_C) begin
               tx_we = 1'b1;
               tx_count_in = tx_count_ff + CNT_W'(1);
            end
         end
         default: begin
         end
      endcase

      out_in.tx_irq_enabled = tx_irq_in;
      out_in.rx_level = 7'(rx_count_in);
      out_in.tx_level = 7'(tx_count_in);

      if (!exec) begin
         rx_we = 1'b0;
         rx_re = 1'b0;
         tx_we = 1'b0;
         tx_re = 1'b0;
      end
   end

   uirb_ram #(.WIDTH(8), .DEPTH(RING_DEPTH)) u_rx_ring (
      .clock   (clock),
      .wr_en   (rx_we),
      .wr_addr (rx_tail),
      .wr_data (rx_wd),
      .rd_en   (rx_re),
      .rd_addr (rx_head_ff),
      .rd_data (rx_q)
   );

   uirb_ram #(.WIDTH(8), .DEPTH(RING_DEPTH)) u_tx_ring (
      .clock   (clock),
      .wr_en   (tx_we),
      .wr_addr (tx_tail),
      .wr_data (tx_wd),
      .rd_en   (tx_re),
      .rd_addr (tx_head_ff),
      .rd_data (tx_q)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         rx_head_ff   <= '0;
         rx_count_ff  <= '0;
         tx_head_ff   <= '0;
         tx_count_ff  <= '0;
         tx_irq_ff    <= 1'b0;
      end else begin
         if (req_ready) begin
            in_valid_ff <= req_valid;
         end
         if (advance) begin
            out_valid_ff <= in_valid_ff;
         end
         if (exec) begin
            rx_head_ff  <= rx_head_in;
            rx_count_ff <= rx_count_in;
            tx_head_ff  <= tx_head_in;
            tx_count_ff <= tx_count_in;
            tx_irq_ff   <= tx_irq_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ff <= req_data;
      end
      if (exec) begin
         out_ff <= out_in;
      end
   end

   always_comb begin
      rsp_data = out_ff;
      if (out_ff.tx_valid) begin
         rsp_data.tx_byte = tx_q;
      end
      if (out_ff.read_valid) begin
         rsp_data.read_byte = (rx_q == CHAR_CR) ? CHAR_LF : rx_q;
      end
   end

   assign rsp_valid = out_valid_ff;

`ifndef SYNTHESIS
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      rx_count_ff <= DEPTH_C && tx_count_ff <= DEPTH_C)
      else $error("ring count exceeds depth");

   a_ram_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> $stable(rsp_data))
      else $error("result word changed under a stalled result");

   a_pop_count: assert property (@(posedge clock) disable iff (reset)
      tx_re |=> tx_count_ff == $past(tx_count_ff) - CNT_W'(1))
      else $error("transmit pop did not lower the count");

   a_irq_fall: assert property (@(posedge clock) disable iff (reset)
      $fell(tx_irq_ff) |-> $past(exec) && $past(tx_count_ff) == CNT_W'(1))
      else $error("enable bit cleared while the transmit ring was not emptied");
`endif

endmodule
